// ===== rtl/core/int8_mac_requantize_assert.svh =====
// assertion macros used by the requantizer queue
`ifndef INT8_MAC_REQUANTIZE_ASSERT_SVH
`define INT8_MAC_REQUANTIZE_ASSERT_SVH

// property must hold at every clock edge outside reset
`define IMR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define IMR_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== rtl/core/imr_pkg.sv =====
`default_nettype none
package imr_pkg;

   // configuration register indexes
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_INPUT_ZERO_POINT  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_OUTPUT_ZERO_POINT = 2'd1;
   localparam int CSR_DATA_WIDTH = 8;

   // queue between accumulate front and requantize back
   localparam int QUEUE_DEPTH       = 2;
   localparam int QUEUE_PTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   // fixed-point constants
   localparam logic signed [31:0] INT32_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;
   localparam logic signed [63:0] ROUND_Q31 = 64'sd1073741824;
   localparam logic signed [34:0] INT8_MAX  = 35'sd127;
   localparam logic signed [34:0] INT8_MIN  = -35'sd128;

   // one element ready for requantization
   typedef struct packed {
      logic signed [31:0] acc;
      logic signed [31:0] mult;
      logic signed [5:0]  shift;
   } imr_entry_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MUL,
      BK_SCALE,
      BK_ROUND
   } imr_back_state_type;

endpackage
`default_nettype wire

// ===== rtl/core/imr_ifs.sv =====
`default_nettype none

// input channel: one activation and weight pair
interface imr_req_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] activation;
   logic              pad;
   logic signed [7:0] weight_value;
   logic signed [31:0] bias;
   logic signed [31:0] multiplier;
   logic signed [5:0] shift_amount;
   logic              first;
   logic              last;

   modport source (output valid, activation, pad, weight_value, bias, multiplier,
                   shift_amount, first, last, input ready);
   modport sink (input valid, activation, pad, weight_value, bias, multiplier,
                 shift_amount, first, last, output ready);
endinterface

// result channel: one int8 output value
interface imr_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] output_value;

   modport source (output valid, output_value, input ready);
   modport sink (input valid, output_value, output ready);
endinterface

// configuration write channel
interface imr_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [imr_pkg::CSR_INDEX_WIDTH-1:0]   index;
   logic [imr_pkg::CSR_DATA_WIDTH-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/imr_front.sv =====
`default_nettype none
module imr_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   imr_req_if.sink                   req_ch,
   input  wire logic signed [7:0]    input_zero_point,
   input  wire logic                 queue_full,
   output      logic                 push,
   output      imr_pkg::imr_entry_type push_entry
);

   logic signed [31:0] acc_ff;
   logic signed [31:0] acc_in;
   logic signed [7:0]  act;
   logic signed [15:0] prod;
   logic signed [31:0] base;
   logic               accept;

   // take a transaction whenever the queue can hold a possible result
   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && !queue_full;

   // multiply-accumulate, bias loads on the first pair
   always_comb begin
      act    = req_ch.pad ? input_zero_point : req_ch.activation;
      prod   = act * req_ch.weight_value;
      base   = req_ch.first ? req_ch.bias : acc_ff;
      acc_in = base + {{16{prod[15]}}, prod};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (accept) begin
         acc_ff <= acc_in;
      end
   end

   // last pair hands the finished sum to the back end
   assign push             = accept && req_ch.last;
   assign push_entry.acc   = acc_in;
   assign push_entry.mult  = req_ch.multiplier;
   assign push_entry.shift = req_ch.shift_amount;

endmodule
`default_nettype wire

// ===== rtl/core/imr_queue.sv =====
`default_nettype none
module imr_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire imr_pkg::imr_entry_type push_entry,
   input  wire logic                   pop,
   output      imr_pkg::imr_entry_type head,
   output      logic                   full,
   output      logic                   empty
);

   imr_pkg::imr_entry_type                  mem_ff [imr_pkg::QUEUE_DEPTH];
   logic [imr_pkg::QUEUE_PTR_WIDTH-1:0]     wr_ptr_ff;
   logic [imr_pkg::QUEUE_PTR_WIDTH-1:0]     rd_ptr_ff;
   logic [imr_pkg::QUEUE_COUNT_WIDTH-1:0]   count_ff;
   logic [imr_pkg::QUEUE_COUNT_WIDTH-1:0]   count_in;

   localparam logic [imr_pkg::QUEUE_PTR_WIDTH-1:0] LAST_PTR =
      imr_pkg::QUEUE_PTR_WIDTH'(imr_pkg::QUEUE_DEPTH - 1);
   localparam logic [imr_pkg::QUEUE_COUNT_WIDTH-1:0] DEPTH_COUNT =
      imr_pkg::QUEUE_COUNT_WIDTH'(imr_pkg::QUEUE_DEPTH);

   assign full  = (count_ff == DEPTH_COUNT);
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   // occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

`include "int8_mac_requantize_assert.svh"

   `IMR_ASSERT(a_count_bound, clock, reset, count_ff <= DEPTH_COUNT, "queue over depth")
   `IMR_ASSERT_NEVER(a_push_full, clock, reset, push && full, "push into full queue")
   `IMR_ASSERT_NEVER(a_pop_empty, clock, reset, pop && empty, "pop from empty queue")
   `IMR_ASSERT(a_push_count, clock, reset, push && !pop |=> count_ff == $past(count_ff) + 1'b1, "push lost")

endmodule
`default_nettype wire

// ===== rtl/core/imr_back.sv =====
`default_nettype none
module imr_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire imr_pkg::imr_entry_type head,
   input  wire logic                   empty,
   output      logic                   pop,
   input  wire logic signed [7:0]      output_zero_point,
   imr_rsp_if.source                   rsp_ch
);

   imr_pkg::imr_back_state_type state_ff, state_in;

   logic signed [31:0] x_ff, x_in;
   logic signed [31:0] mult_ff;
   logic signed [5:0]  shift_ff;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [31:0] h_ff, h_in;
   logic               rsp_valid_ff;
   logic signed [7:0]  rsp_value_ff, rsp_value_in;

   logic signed [62:0] wide;
   logic signed [63:0] biased;
   logic [5:0]         rshift;
   logic signed [33:0] rnd_sum;
   logic signed [33:0] rounded;
   logic signed [34:0] zp_sum;
   logic               load_x;
   logic               load_out;

   // saturating left shift of the queue head
   always_comb begin
      wide = {{31{head.acc[31]}}, head.acc} <<< head.shift[4:0];
      x_in = head.acc;
      if (head.shift > 6'sd0) begin
         if (wide[62:31] == {32{wide[62]}}) begin
            x_in = wide[31:0];
         end else begin
            x_in = wide[62] ? imr_pkg::INT32_MIN : imr_pkg::INT32_MAX;
         end
      end
   end

   // q31 multiply and rounding doubling high part
   assign prod_in = x_ff * mult_ff;
   assign biased  = prod_ff + imr_pkg::ROUND_Q31;
   assign h_in    = biased[62:31];

   // rounding right shift, output offset and int8 clip
   always_comb begin
      rshift  = 6'(-shift_ff);
      rnd_sum = {{2{h_ff[31]}}, h_ff} + (34'sd1 <<< (rshift - 6'd1));
      rounded = {{2{h_ff[31]}}, h_ff};
      if (shift_ff < 6'sd0) begin
         rounded = rnd_sum >>> rshift;
      end
      zp_sum = {rounded[33], rounded} + {{27{output_zero_point[7]}}, output_zero_point};
      if (zp_sum > imr_pkg::INT8_MAX) begin
         rsp_value_in = 8'sd127;
      end else if (zp_sum < imr_pkg::INT8_MIN) begin
         rsp_value_in = -8'sd128;
      end else begin
         rsp_value_in = zp_sum[7:0];
      end
   end

   // sequencer: one element at a time through the four steps
   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      load_x   = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         imr_pkg::BK_IDLE: begin
            if (!empty) begin
               pop      = 1'b1;
               load_x   = 1'b1;
               state_in = imr_pkg::BK_MUL;
            end
         end
         imr_pkg::BK_MUL: begin
            state_in = imr_pkg::BK_SCALE;
         end
         imr_pkg::BK_SCALE: begin
            state_in = imr_pkg::BK_ROUND;
         end
         imr_pkg::BK_ROUND: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               load_out = 1'b1;
               state_in = imr_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = imr_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= imr_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (load_x) begin
         x_ff     <= x_in;
         mult_ff  <= head.mult;
         shift_ff <= head.shift;
      end
      if (state_ff == imr_pkg::BK_MUL) begin
         prod_ff <= prod_in;
      end
      if (state_ff == imr_pkg::BK_SCALE) begin
         h_ff <= h_in;
      end
      if (load_out) begin
         rsp_value_ff <= rsp_value_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.output_value = rsp_value_ff;

endmodule
`default_nettype wire

// ===== rtl/core/int8_mac_requantize.sv =====
// int8 multiply-accumulate with fixed-point requantization. Each request
// transaction carries one activation/weight pair; pad substitutes the input
// zero point, first loads bias into the 32-bit wrapping accumulator, last
// ends the element and yields one int8 response. The accumulate front takes
// one transaction per cycle. Each element's requantization runs in the back
// sequencer through saturating shift, 32x32 multiply, rounding high part
// and rounding right shift with offset and clip, one element at a time, so
// the back takes no new element until the last one's response is loaded; a
// two-entry queue between front and back lets up to two finished elements
// wait, and the front stalls only when the queue is full. The csr port accepts
// a write every cycle; write the zero points only while no element is in flight.
`default_nettype none
module int8_mac_requantize (
   input  wire logic  clock,
   input  wire logic  reset,
   imr_req_if.sink    req_ch,
   imr_rsp_if.source  rsp_ch,
   imr_csr_if.sink    csr_ch
);

   logic signed [7:0]      input_zp_ff;
   logic signed [7:0]      output_zp_ff;
   logic                   push;
   logic                   pop;
   logic                   queue_full;
   logic                   queue_empty;
   imr_pkg::imr_entry_type push_entry;
   imr_pkg::imr_entry_type head;

   // configuration registers
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         input_zp_ff  <= '0;
         output_zp_ff <= '0;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            imr_pkg::REG_INPUT_ZERO_POINT:  input_zp_ff  <= csr_ch.data;
            imr_pkg::REG_OUTPUT_ZERO_POINT: output_zp_ff <= csr_ch.data;
            default: begin
            end
         endcase
      end
   end

   imr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .input_zero_point (input_zp_ff),
      .queue_full       (queue_full),
      .push             (push),
      .push_entry       (push_entry)
   );

   imr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .full       (queue_full),
      .empty      (queue_empty)
   );

   imr_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .empty             (queue_empty),
      .pop               (pop),
      .output_zero_point (output_zp_ff),
      .rsp_ch            (rsp_ch)
   );

endmodule
`default_nettype wire
